// ===== hw/rtl/insr_pkg.sv =====
// Package for the insertion sorter: data width, store depth, the cell
// state struct and the operation codes that the top level sends to every cell.
// No dependencies.
package insr_pkg;

  // Width of one sorted value and number of cells in the chain (2 to 64).
  localparam int unsigned WIDTH = 32;
  localparam int unsigned DEPTH = 64;

  // What every cell does in a given cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } op_e;

  // State a cell shows to its neighbors.
  typedef struct packed {
    logic                    valid;
    logic                    gt;
    logic signed [WIDTH-1:0] value;
  } cell_t;

endpackage

// ===== hw/rtl/insertion_sorter.sv =====
// Insertion sorter: a chain of DEPTH cells inserts one value per cycle, in a stable
// ascending order. A transaction marked last is followed by the sorted run, drained
// from the bottom cell at one result per cycle unless the receiver stalls; input
// stalls until the run is taken. The first result is presented in the cycle after the
// last input is taken. Reset empties all cells and clears the flags.
// Depends on insr_pkg and insr_cell.
module insertion_sorter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [insr_pkg::WIDTH-1:0] value_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [insr_pkg::WIDTH-1:0] sorted_value_o,
  output logic                              end_of_run_o,
  output logic                              overflow_o
);
  import insr_pkg::*;

  localparam cell_t BottomEdge = '{valid: 1'b1, gt: 1'b0, value: '0};
  localparam cell_t TopEdge    = '{valid: 1'b0, gt: 1'b0, value: '0};

  cell_t            cells [DEPTH];
  logic [DEPTH-1:0] valid_vec;
  op_e              op;
  logic             in_accept, out_accept, full;
  logic             draining_q, draining_d;
  logic             dropped_q, dropped_d;

  // The chain of cells; cell 0 holds the smallest value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_t left, right;
    if (i == 0) begin : g_bottom
      assign left = BottomEdge;
    end else begin : g_lower
      assign left = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign right = TopEdge;
    end else begin : g_upper
      assign right = cells[i+1];
    end
    assign valid_vec[i] = cells[i].valid;

    insr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .new_value_i (value_i),
      .left_i      (left),
      .right_i     (right),
      .cell_o      (cells[i])
    );
  end

  // Handshakes and chain operation.
  assign full       = valid_vec[DEPTH-1];
  assign in_stall_o = draining_q;
  assign in_accept  = in_valid_i && !draining_q;
  assign out_accept = out_valid_o && !out_stall_i;

  always_comb begin
    priority if (in_accept && !full) begin
      op = OP_INSERT;
    end else if (out_accept) begin
      op = OP_SHIFT;
    end else begin
      op = OP_HOLD;
    end
  end

  // Drain and overflow control.
  always_comb begin
    draining_d = draining_q;
    dropped_d  = dropped_q;
    if (in_accept) begin
      if (full) begin
        dropped_d = 1'b1;
      end
      if (last_i) begin
        draining_d = 1'b1;
      end
    end
    if (out_accept && end_of_run_o) begin
      draining_d = 1'b0;
      dropped_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      draining_q <= draining_d;
      dropped_q  <= dropped_d;
    end
  end

  // Results come straight from the bottom cell.
  assign out_valid_o    = draining_q && cells[0].valid;
  assign sorted_value_o = cells[0].value;
  assign end_of_run_o   = !cells[1].valid;
  assign overflow_o     = dropped_q;

`ifndef SYNTHESIS
  // Occupied cells always form a contiguous run from the bottom.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + DEPTH'(1))) == '0)
    else $error("occupied cells are not contiguous");

  // A drain always has a result to present.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> cells[0].valid)
    else $error("draining with an empty chain");

  // The last transaction starts the sorted run in the next cycle.
  a_run_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_i) |=> out_valid_o)
    else $error("sorted run did not start after last input");

  // Taking the final result leaves the chain empty and the input open.
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_accept && end_of_run_o) |=> (!cells[0].valid && !in_stall_o && !overflow_o))
    else $error("chain not empty after end of run");
`endif

endmodule

// ===== hw/rtl/insr_cell.sv =====
// One compare-and-shift cell of the insertion sorter chain.
// Depends on insr_pkg for the cell struct and the operation codes.
module insr_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  insr_pkg::op_e                    op_i,
  input  logic signed [insr_pkg::WIDTH-1:0] new_value_i,
  input  insr_pkg::cell_t                  left_i,
  input  insr_pkg::cell_t                  right_i,
  output insr_pkg::cell_t                  cell_o
);
  import insr_pkg::*;

  logic                    valid_q, valid_d;
  logic signed [WIDTH-1:0] value_q, value_d;
  logic                    gt;

  // A held value strictly greater than the new one moves up; equal values stay.
  assign gt = valid_q && (value_q > new_value_i);

  // Next state: insert takes the lower neighbor or the new value, drain takes the upper.
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    unique case (op_i)
      OP_INSERT: begin
        if (left_i.gt) begin
          valid_d = 1'b1;
          value_d = left_i.value;
        end else if (gt || (!valid_q && left_i.valid)) begin
          valid_d = 1'b1;
          value_d = new_value_i;
        end
      end
      OP_SHIFT: begin
        valid_d = right_i.valid;
        value_d = right_i.value;
      end
      default: begin
        valid_d = valid_q;
        value_d = value_q;
      end
    endcase
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stored value.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o = '{valid: valid_q, gt: gt, value: value_q};

endmodule

// ===== test/tb.sv =====
// Testbench for insertion_sorter: sends sets of signed values and checks every sorted run
// against a queue-based model of a stable ascending sort that drops values when the store is full.
// Depends on insr_pkg and the insertion_sorter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = insr_pkg::WIDTH;
  localparam int D = insr_pkg::DEPTH;
  localparam int ITEM_TARGET = 330;
  localparam int MAX_REPORTS = 10;

  // One expected result of a sorted run.
  typedef struct {
    logic signed [W-1:0] value;
    logic                end_of_run;
    logic                overflow;
  } run_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [W-1:0] value_i = '0;
  logic                last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic signed [W-1:0] sorted_value_o;
  logic                end_of_run_o;
  logic                overflow_o;

  // Model state: the sorted values of the open set and the drop flag.
  logic signed [W-1:0] sorted_model[$];
  logic                model_dropped = 1'b0;
  run_result_t         pending_results[$];

  int  items_sent = 0;
  int  mismatches = 0;
  bit  idle_enable = 1'b0;

  insertion_sorter u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .end_of_run_o   (end_of_run_o),
    .overflow_o     (overflow_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  // Idle length: mostly none or short, a few long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values lean toward the extremes and a narrow band that yields duplicates.
  function automatic logic signed [W-1:0] rand_value();
    logic signed [W-1:0] near_zero;
    near_zero = $urandom_range(0, 8);
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2, 3, 4: return near_zero - 4;
      default: return $urandom;
    endcase
  endfunction

  // Set sizes: mostly small, some medium, some that fill or overrun the store.
  function automatic int rand_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 10);
    if (r < 85) return $urandom_range(11, 40);
    if (r < 95) return $urandom_range(D - 1, D);
    return $urandom_range(D + 1, D + 6);
  endfunction

  // Insert an accepted value into the model; a last value emits the sorted run.
  task automatic sort_accept(input logic signed [W-1:0] v, input logic l);
    int pos;
    run_result_t res;
    if (sorted_model.size() >= D) begin
      model_dropped = 1'b1;
    end else begin
      // Stable: the new value goes after every equal value already held.
      pos = sorted_model.size();
      while (pos > 0 && sorted_model[pos-1] > v) pos--;
      sorted_model.insert(pos, v);
    end
    if (l) begin
      foreach (sorted_model[k]) begin
        res.value      = sorted_model[k];
        res.end_of_run = (k == sorted_model.size() - 1);
        res.overflow   = model_dropped;
        pending_results.push_back(res);
      end
      sorted_model.delete();
      model_dropped = 1'b0;
    end
  endtask

  // Send one transaction and wait until it is accepted; with idling enabled, valid then drops for a random gap.
  task automatic send_value(input logic signed [W-1:0] v, input logic l);
    int gap;
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    do @(posedge clk_i); while (in_stall_o);
    sort_accept(v, l);
    items_sent++;
    gap = idle_enable ? rand_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) send_value(rand_value(), i == n - 1);
  endtask

  // Hold the sender until every expected result has come.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sets of one value, extremes and duplicates, descending order.
  task automatic test_directed();
    logic signed [W-1:0] mixed[10];
    idle_enable = 1'b0;
    send_value({1'b1, {(W-1){1'b0}}}, 1'b1);
    send_value({1'b0, {(W-1){1'b1}}}, 1'b1);
    send_value('0, 1'b1);
    mixed = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1,
              32'h7fff_ffff, 32'h8000_0000, 32'h5, 32'h5, 32'hffff_fffb};
    foreach (mixed[i]) send_value(mixed[i], i == 9);
    for (int i = 0; i < 5; i++) send_value(100 - 10 * i, i == 4);
    wait_drained();
  endtask

  // Exactly full store, then an overrun whose last value is itself dropped.
  task automatic test_full_store();
    idle_enable = 1'b0;
    send_random_set(D);
    wait_drained();
    for (int i = 0; i < D + 3; i++) send_value($urandom, i == D + 2);
    wait_drained();
  endtask

  // Random sets with random idling, some stretches without any, and periodic draining.
  task automatic test_random_runs();
    int sets;
    int n;
    sets = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_enable = ($urandom_range(0, 4) != 0);
      n = rand_set_size();
      // The final set is trimmed so the total lands on the target.
      if (n > ITEM_TARGET - items_sent) n = ITEM_TARGET - items_sent;
      send_random_set(n);
      sets++;
      if (sets % 5 == 0) wait_drained();
    end
    idle_enable = 1'b1;
    wait_drained();
  endtask

  // Receiver stall pattern, driven at the rising edge.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (!idle_enable) begin
        out_stall_i <= 1'b0;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if (out_stall_i) begin
        out_stall_i <= 1'b0;
        hold = $urandom_range(0, 6);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        hold = rand_gap();
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    run_result_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: value %0d end_of_run %0b overflow %0b",
                   sorted_value_o, end_of_run_o, overflow_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (sorted_value_o !== exp_res.value || end_of_run_o !== exp_res.end_of_run ||
            overflow_o !== exp_res.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b (value/end/ovf)",
                     exp_res.value, exp_res.end_of_run, exp_res.overflow,
                     sorted_value_o, end_of_run_o, overflow_o);
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_store();
    test_random_runs();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
